[rtl/slrp_pkg.sv]
// Shared types and constants for the server-list record parser.
package slrp_pkg;

    localparam int unsigned CNT_W = 11;
    localparam int unsigned REC_W = 48;

    localparam logic [7:0]       BACKSLASH   = 8'h5C;
    localparam logic [23:0]      EOT_MARK    = 24'h454F54;
    localparam logic [CNT_W-1:0] CAP_DEFAULT = 11'd1024;

    typedef enum logic [1:0] {
        V_ADDED = 2'd0,
        V_DUP   = 2'd1,
        V_FULL  = 2'd2,
        V_PORT0 = 2'd3
    } t_verdict;

    typedef struct packed {
        logic             start;
        logic [REC_W-1:0] rec;
    } t_eng_req;

    typedef struct packed {
        logic     done;
        t_verdict verdict;
    } t_eng_rsp;

endpackage

[rtl/slrp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module slrp_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/slrp_engine.sv]
// Table engine: duplicate scan with one shared comparator, then insert.
module slrp_engine #(
    parameter int unsigned MAX_ENTRIES = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  slrp_pkg::t_eng_req        i_req,
    input  logic [slrp_pkg::CNT_W-1:0] i_capacity,
    output slrp_pkg::t_eng_rsp        o_rsp,
    output logic [slrp_pkg::CNT_W-1:0] o_count
);
    localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW = slrp_pkg::CNT_W;
    localparam int unsigned MW = 17;

    typedef enum logic [1:0] {E_IDLE, E_SCAN, E_DONE} t_estate;

    t_estate                     r_state;
    logic [slrp_pkg::REC_W-1:0]  r_rec;
    logic [CW-1:0]               r_idx;
    logic                        r_pend;
    logic [CW-1:0]               r_count;
    slrp_pkg::t_verdict          r_verdict;

    logic [slrp_pkg::REC_W-1:0]  ram_rdata;
    logic [AW+CW-1:0]            raddr_ext;
    logic [AW+CW-1:0]            waddr_ext;
    logic                        hit;
    logic                        more;
    logic                        full;
    logic                        ram_we;

    assign hit       = r_pend && (ram_rdata == r_rec);
    assign more      = r_idx < r_count;
    assign full      = (r_count >= i_capacity) ||
                       ({{(MW-CW){1'b0}}, r_count} >= MW'(MAX_ENTRIES));
    assign ram_we    = (r_state == E_SCAN) && !hit && !more && !r_pend && !full;
    assign raddr_ext = {{AW{1'b0}}, r_idx};
    assign waddr_ext = {{AW{1'b0}}, r_count};

    slrp_ram #(
        .WIDTH (slrp_pkg::REC_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr_ext[AW-1:0]),
        .i_wdata (r_rec),
        .i_raddr (raddr_ext[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                E_IDLE: begin
                    if (i_req.start) begin
                        r_rec  <= i_req.rec;
                        r_idx  <= '0;
                        r_pend <= 1'b0;
                        if (i_req.rec[15:0] == 16'h0000) begin
                            r_verdict <= slrp_pkg::V_PORT0;
                            r_state   <= E_DONE;
                        end else begin
                            r_state <= E_SCAN;
                        end
                    end
                end
                E_SCAN: begin
                    if (hit) begin
                        r_verdict <= slrp_pkg::V_DUP;
                        r_state   <= E_DONE;
                    end else if (more) begin
                        // read of entry r_idx lands next cycle
                        r_idx  <= r_idx + CW'(1);
                        r_pend <= 1'b1;
                    end else if (r_pend) begin
                        r_pend <= 1'b0;
                    end else if (full) begin
                        r_verdict <= slrp_pkg::V_FULL;
                        r_state   <= E_DONE;
                    end else begin
                        r_verdict <= slrp_pkg::V_ADDED;
                        r_count   <= r_count + CW'(1);
                        r_state   <= E_DONE;
                    end
                end
                E_DONE: begin
                    r_state <= E_IDLE;
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done    = (r_state == E_DONE);
    assign o_rsp.verdict = r_verdict;
    assign o_count       = r_count;
endmodule

[rtl/server_list_record_parser.sv]
// Top level of the server-list record parser: byte parser, result sequencer, output register.
//
//  channel  direction  handshake                    payload
//  -------  ---------  ---------------------------  ---------------------------------------
//  in       to block   i_in_valid / o_in_stall      i_data_byte, i_last_byte
//  out      from block o_out_valid / i_out_stall    o_result_kind .. o_final_result
//  cfg      to block   i_cfg_we                     i_cfg_wdata (capacity)
//
// A byte with no result leaves the block idle; a last byte without a record leads to
// a summary. A record goes through the table engine: port zero skips the search, else
// one entry read per cycle over the entries held; a last byte adds a summary.
// o_in_stall is high from the accept of a result-bearing byte until its last result
// is loaded into the output register; a held output register extends that.
// Sync active-low reset; table RAM is not cleared, only entries below the count are read.
module server_list_record_parser #(
    parameter int unsigned MAX_ENTRIES = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_last_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_result_kind,
    output logic [31:0]                 o_address,
    output logic [15:0]                 o_port_number,
    output logic [1:0]                  o_verdict,
    output logic [slrp_pkg::CNT_W-1:0]  o_added_in_packet,
    output logic [slrp_pkg::CNT_W-1:0]  o_entries_held,
    output logic                        o_final_result,
    input  logic                        i_cfg_we,
    input  logic [slrp_pkg::CNT_W-1:0]  i_cfg_wdata
);
    localparam int unsigned CW = slrp_pkg::CNT_W;
    localparam int unsigned RW = slrp_pkg::REC_W;

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_VERDICT, S_SUMMARY} t_state;
    typedef enum logic [1:0] {PH_SEEK, PH_RECORD, PH_IGNORE} t_phase;

    t_state              r_state;
    t_phase              r_phase, n_phase;
    logic [2:0]          r_pos, n_pos;
    logic [RW-1:0]       r_buf, n_buf;
    logic [RW-1:0]       r_rec;
    logic                r_last;
    logic [CW-1:0]       r_added;
    logic [CW-1:0]       r_capacity;
    slrp_pkg::t_verdict  r_verdict;

    // output register
    logic                r_out_valid;
    logic                r_out_kind;
    logic [31:0]         r_out_addr;
    logic [15:0]         r_out_port;
    logic [1:0]          r_out_verdict;
    logic [CW-1:0]       r_out_added;
    logic [CW-1:0]       r_out_held;
    logic                r_out_final;

    logic                accept;
    logic                out_free;
    logic                out_load;
    logic                rec_done;
    logic [RW-1:0]       shifted;
    logic [2:0]          pos_inc;
    slrp_pkg::t_eng_req  eng_req;
    slrp_pkg::t_eng_rsp  eng_rsp;
    logic [CW-1:0]       eng_count;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    // a result goes into the output register this cycle
    assign out_load   = ((r_state == S_VERDICT) || (r_state == S_SUMMARY)) && out_free;

    // Byte parser: next phase, position and buffer for the byte on the port.
    always_comb begin
        shifted  = {r_buf[RW-9:0], i_data_byte};
        pos_inc  = r_pos + 3'd1;
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_buf    = r_buf;
        rec_done = 1'b0;
        unique case (r_phase)
            PH_RECORD: begin
                n_buf = shifted;
                n_pos = pos_inc;
                if (pos_inc == 3'd3 && shifted[23:0] == slrp_pkg::EOT_MARK) begin
                    n_phase = PH_IGNORE;
                end else if (pos_inc >= 3'd6) begin
                    rec_done = 1'b1;
                    n_phase  = PH_SEEK;
                    n_pos    = '0;
                    n_buf    = '0;
                end
            end
            PH_IGNORE: begin
            end
            default: begin
                if (i_data_byte == slrp_pkg::BACKSLASH) begin
                    n_phase = PH_RECORD;
                    n_pos   = '0;
                    n_buf   = '0;
                end
            end
        endcase
        // end of packet: parser back to its reset state
        if (i_last_byte) begin
            n_phase = PH_SEEK;
            n_pos   = '0;
            n_buf   = '0;
        end
    end

    assign eng_req.start = accept && rec_done;
    assign eng_req.rec   = shifted;

    slrp_engine #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (eng_req),
        .i_capacity (r_capacity),
        .o_rsp      (eng_rsp),
        .o_count    (eng_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_SEEK;
            r_pos       <= '0;
            r_buf       <= '0;
            r_added     <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
            r_capacity  <= slrp_pkg::CAP_DEFAULT;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_phase <= n_phase;
                        r_pos   <= n_pos;
                        r_buf   <= n_buf;
                        r_last  <= i_last_byte;
                        if (rec_done) begin
                            r_rec   <= shifted;
                            r_state <= S_SEARCH;
                        end else if (i_last_byte) begin
                            r_state <= S_SUMMARY;
                        end
                    end
                end
                S_SEARCH: begin
                    if (eng_rsp.done) begin
                        r_verdict <= eng_rsp.verdict;
                        if (eng_rsp.verdict == slrp_pkg::V_ADDED) begin
                            r_added <= r_added + CW'(1);
                        end
                        r_state <= S_VERDICT;
                    end
                end
                S_VERDICT: begin
                    if (out_free) begin
                        r_out_kind    <= 1'b0;
                        r_out_addr    <= r_rec[RW-1:16];
                        r_out_port    <= r_rec[15:0];
                        r_out_verdict <= r_verdict;
                        r_out_added   <= r_added;
                        r_out_held    <= eng_count;
                        r_out_final   <= !r_last;
                        r_state       <= r_last ? S_SUMMARY : S_IDLE;
                    end
                end
                S_SUMMARY: begin
                    if (out_free) begin
                        r_out_kind    <= 1'b1;
                        r_out_addr    <= '0;
                        r_out_port    <= '0;
                        r_out_verdict <= slrp_pkg::V_ADDED;
                        r_out_added   <= r_added;
                        r_out_held    <= eng_count;
                        r_out_final   <= 1'b1;
                        r_added       <= '0;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_result_kind     = r_out_kind;
    assign o_address         = r_out_addr;
    assign o_port_number     = r_out_port;
    assign o_verdict         = r_out_verdict;
    assign o_added_in_packet = r_out_added;
    assign o_entries_held    = r_out_held;
    assign o_final_result    = r_out_final;

`ifndef ASSERT_OFF
    // the engine only finishes a search the sequencer is waiting on
    a_done_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_rsp.done |-> r_state == S_SEARCH)
        else $error("engine done outside search");

    // the table grows by at most one entry per step
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && eng_count != $past(eng_count))
            |-> eng_count == $past(eng_count) + CW'(1))
        else $error("entry count jumped");

    // a summary transaction is always the last result of its byte
    a_summary_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind) |-> r_out_final)
        else $error("summary not marked final");

    // an added verdict always leaves a nonzero packet count
    a_added_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_kind && r_out_verdict == slrp_pkg::V_ADDED)
            |-> r_out_added != '0)
        else $error("added record with zero packet count");
`endif
endmodule

[bench/tb_server_list_record_parser.sv]
// Testbench for server_list_record_parser: directed table, random packets, predictor check.
module tb_server_list_record_parser;

    localparam int unsigned    MAX_ENTRIES = 1024;
    localparam int unsigned    CW          = slrp_pkg::CNT_W;
    localparam int unsigned    RW          = slrp_pkg::REC_W;
    localparam int unsigned    N_PHASES    = 6;
    localparam int unsigned    PHASE_ITEMS = 185;
    localparam int unsigned    LONG_HOLD   = 400;
    localparam int unsigned    SETTLE      = 8;
    localparam int unsigned    TAIL_WAIT   = 32;
    localparam longint         CYCLE_LIMIT = 2_000_000;
    localparam int unsigned    DIR_ROWS    = 28;

    // Parser position as the predictor tracks it.
    typedef enum logic [1:0] {
        SCAN_SEEK   = 2'd0,
        SCAN_RECORD = 2'd1,
        SCAN_SKIP   = 2'd2
    } t_scan_state;

    // One output transaction, field by field.
    typedef struct packed {
        logic               kind;
        logic [31:0]        addr;
        logic [15:0]        port;
        slrp_pkg::t_verdict verdict;
        logic [CW-1:0]      added;
        logic [CW-1:0]      held;
        logic               fin;
    } t_parse_result;

    // Directed stimulus row; typed rows carry their single expected transaction.
    typedef struct packed {
        logic [7:0]    data;
        logic          last;
        logic          typed;
        t_parse_result want;
    } t_dir_row;

    localparam t_parse_result NO_RESULT = '0;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    logic [7:0]       data_byte = '0;
    logic             last_byte = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic             result_kind;
    logic [31:0]      address;
    logic [15:0]      port_number;
    logic [1:0]       verdict;
    logic [CW-1:0]    added_in_packet;
    logic [CW-1:0]    entries_held;
    logic             final_result;
    logic             cfg_we    = 1'b0;
    logic [CW-1:0]    cfg_wdata = '0;

    always #4 clk = ~clk;

    server_list_record_parser #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_data_byte      (data_byte),
        .i_last_byte      (last_byte),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_result_kind    (result_kind),
        .o_address        (address),
        .o_port_number    (port_number),
        .o_verdict        (verdict),
        .o_added_in_packet(added_in_packet),
        .o_entries_held   (entries_held),
        .o_final_result   (final_result),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the parser and its server table
    // ------------------------------------------------------------------
    t_scan_state      scan_state = SCAN_SEEK;
    logic [RW-1:0]    rec_buf    = '0;
    int unsigned      rec_pos    = 0;
    int unsigned      held_cnt   = 0;
    int unsigned      pkt_added  = 0;
    int unsigned      cap_reg    = slrp_pkg::CAP_DEFAULT;
    logic [RW-1:0]    srv_table [MAX_ENTRIES];

    t_parse_result    step_results [$];   // transactions caused by the byte just accepted
    t_parse_result    result_q [$];       // expected transactions, oldest first
    logic [7:0]       pkt [$];            // bytes of the packet being sent
    logic [RW-1:0]    known_pairs [$];    // pairs already offered, reused for duplicates

    int unsigned      err_cnt      = 0;
    int unsigned      bytes_sent   = 0;
    int unsigned      packets_seen = 0;
    int unsigned      verdict_cnt [4] = '{0, 0, 0, 0};
    bit               snd_quiet    = 1'b0;
    bit               long_hold_req = 1'b0;
    longint           cycle_cnt    = 0;
    int unsigned      cap_plan [N_PHASES] = '{3, 0, 2047, 1, 1024, 6};

    // Directed part: extremes of address and port, port zero, a duplicate on the
    // packet's last byte (record verdict plus summary), the terminator right at
    // the end of a packet, and a record cut short by the last byte.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},          // leading filler, ignored
        '{slrp_pkg::BACKSLASH, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b1,                       // 0.0.0.0:65535 goes in first
          '{1'b0, 32'h0000_0000, 16'hFFFF, slrp_pkg::V_ADDED, 11'd1, 11'd1, 1'b1}},
        '{slrp_pkg::BACKSLASH, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b1,                       // port zero, table untouched
          '{1'b0, 32'hFFFF_FFFF, 16'h0000, slrp_pkg::V_PORT0, 11'd1, 11'd1, 1'b1}},
        '{slrp_pkg::BACKSLASH, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, 1'b0, NO_RESULT},          // duplicate, then summary
        '{slrp_pkg::BACKSLASH, 1'b0, 1'b0, NO_RESULT},
        '{slrp_pkg::EOT_MARK[23:16], 1'b0, 1'b0, NO_RESULT},
        '{slrp_pkg::EOT_MARK[15:8], 1'b0, 1'b0, NO_RESULT},
        '{slrp_pkg::EOT_MARK[7:0], 1'b1, 1'b1,     // terminator ends the packet
          '{1'b1, 32'h0, 16'h0, slrp_pkg::V_ADDED, 11'd0, 11'd1, 1'b1}},
        '{slrp_pkg::BACKSLASH, 1'b0, 1'b0, NO_RESULT},
        '{8'h01, 1'b1, 1'b1,                       // cut-short record dropped
          '{1'b1, 32'h0, 16'h0, slrp_pkg::V_ADDED, 11'd0, 11'd1, 1'b1}}
    };

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic t_parse_result mk_result(logic kind, logic [31:0] a, logic [15:0] p,
                                                slrp_pkg::t_verdict v, logic fin);
        t_parse_result r;
        r.kind    = kind;
        r.addr    = a;
        r.port    = p;
        r.verdict = v;
        r.added   = CW'(pkt_added);
        r.held    = CW'(held_cnt);
        r.fin     = fin;
        return r;
    endfunction

    // Port zero is rejected before any search; the duplicate search runs ahead
    // of the capacity test, so known pairs are found even with the table full.
    function automatic slrp_pkg::t_verdict judge_record(logic [RW-1:0] rec);
        int unsigned lim;
        lim = (cap_reg < MAX_ENTRIES) ? cap_reg : MAX_ENTRIES;
        if (rec[15:0] == 16'h0000) return slrp_pkg::V_PORT0;
        for (int unsigned j = 0; j < held_cnt; j++)
            if (srv_table[j] == rec) return slrp_pkg::V_DUP;
        if (held_cnt >= lim) return slrp_pkg::V_FULL;
        srv_table[held_cnt] = rec;
        held_cnt++;
        pkt_added++;
        return slrp_pkg::V_ADDED;
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic l);
        slrp_pkg::t_verdict v;
        step_results.delete();
        if (scan_state == SCAN_RECORD) begin
            rec_buf = {rec_buf[RW-9:0], b};
            rec_pos = (rec_pos + 1) & 7;
            if (rec_pos == 3 && rec_buf[23:0] == slrp_pkg::EOT_MARK) begin
                scan_state = SCAN_SKIP;
            end else if (rec_pos >= 6) begin
                v = judge_record(rec_buf);
                step_results.push_back(mk_result(1'b0, rec_buf[RW-1:16], rec_buf[15:0],
                                                 v, !l));
                scan_state = SCAN_SEEK;
                rec_pos    = 0;
                rec_buf    = '0;
            end
        end else if (scan_state != SCAN_SKIP && b == slrp_pkg::BACKSLASH) begin
            scan_state = SCAN_RECORD;
            rec_pos    = 0;
            rec_buf    = '0;
        end
        if (l) begin
            step_results.push_back(mk_result(1'b1, 32'h0, 16'h0, slrp_pkg::V_ADDED, 1'b1));
            scan_state = SCAN_SEEK;
            rec_pos    = 0;
            rec_buf    = '0;
            pkt_added  = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Random packet builder: mostly well-formed replies with random content,
    // some pure noise. Record pairs are often reused to provoke duplicates.
    // ------------------------------------------------------------------
    function automatic void fill_packet();
        int unsigned      n;
        logic [RW-1:0]    pair;
        logic [31:0]      a;
        logic [15:0]      p;
        pkt.delete();
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 20);
            for (int unsigned k = 0; k < n; k++)
                pkt.push_back(($urandom_range(0, 3) == 0) ? slrp_pkg::BACKSLASH
                                                           : 8'($urandom));
        end else begin
            n = $urandom_range(0, 3);
            for (int unsigned k = 0; k < n; k++)
                pkt.push_back($urandom_range(0, 1) ? 8'hFF : 8'($urandom_range(0, 91)));
            n = $urandom_range(0, 5);
            for (int unsigned k = 0; k < n; k++) begin
                if ($urandom_range(0, 3) == 0)
                    pkt.push_back(8'($urandom_range(0, 91)));    // stray byte between records
                pkt.push_back(slrp_pkg::BACKSLASH);
                if (known_pairs.size() != 0 && $urandom_range(0, 2) == 0) begin
                    pair = known_pairs[$urandom_range(0, known_pairs.size() - 1)];
                end else begin
                    case ($urandom_range(0, 7))
                        0:       a = '0;
                        1:       a = '1;
                        default: a = $urandom;
                    endcase
                    case ($urandom_range(0, 7))
                        0:       p = '0;
                        1:       p = '1;
                        default: p = 16'($urandom);
                    endcase
                    pair = {a, p};
                    if (p != 16'h0000) known_pairs.push_back(pair);
                end
                for (int unsigned j = 0; j < 6; j++)
                    pkt.push_back(pair[RW-1-8*j -: 8]);
            end
            case ($urandom_range(0, 3))
                1: begin                                   // terminator, then junk
                    pkt.push_back(slrp_pkg::BACKSLASH);
                    pkt.push_back(slrp_pkg::EOT_MARK[23:16]);
                    pkt.push_back(slrp_pkg::EOT_MARK[15:8]);
                    pkt.push_back(slrp_pkg::EOT_MARK[7:0]);
                    n = $urandom_range(0, 4);
                    for (int unsigned k = 0; k < n; k++) pkt.push_back(8'($urandom));
                end
                2: begin                                   // record cut short
                    pkt.push_back(slrp_pkg::BACKSLASH);
                    n = $urandom_range(0, 5);
                    for (int unsigned k = 0; k < n; k++) pkt.push_back(8'($urandom));
                end
                3: begin
                    n = $urandom_range(1, 3);
                    for (int unsigned k = 0; k < n; k++)
                        pkt.push_back(8'($urandom_range(0, 91)));
                end
                default: ;
            endcase
        end
        if (pkt.size() == 0) pkt.push_back(8'($urandom));
    endfunction

    function automatic void cmp_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            err_cnt++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side: one transaction per call, random gap in front of it.
    // Returns at the edge where the byte was taken; the predictor runs there.
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic l, input logic typed,
                             input t_parse_result want);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) snd_quiet = !snd_quiet;
        gap = snd_quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= l;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_byte(b, l);
        if (typed) begin
            result_q.push_back(want);
        end else begin
            foreach (step_results[k]) result_q.push_back(step_results[k]);
        end
        bytes_sent++;
    endtask

    // Quiesce: stop offering, let every expected transaction drain, then settle.
    task automatic settle(input int unsigned cycles);
        in_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge clk);
        repeat (cycles) @(posedge clk);
    endtask

    // Only called while the block is idle.
    task automatic write_capacity(input int unsigned v);
        cfg_we    <= 1'b1;
        cfg_wdata <= CW'(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cap_reg    = v;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall per transaction, one long hold-off on request
    // so the block backs up and stalls its input.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned   hold;
        bit            quiet;
        t_parse_result got;
        t_parse_result want;
        quiet = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if ($urandom_range(0, 39) == 0) quiet = !quiet;
            hold = quiet ? 0 : $urandom_range(0, 15);
            if (long_hold_req) begin
                hold          = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            got.kind    = result_kind;
            got.addr    = address;
            got.port    = port_number;
            got.verdict = slrp_pkg::t_verdict'(verdict);
            got.added   = added_in_packet;
            got.held    = entries_held;
            got.fin     = final_result;
            if (result_q.size() == 0) begin
                $error("unexpected transaction: kind %0d address 0x%0h port 0x%0h",
                       got.kind, got.addr, got.port);
                err_cnt++;
            end else begin
                want = result_q.pop_front();
                cmp_field("result_kind", want.kind, got.kind);
                cmp_field("address", want.addr, got.addr);
                cmp_field("port_number", want.port, got.port);
                cmp_field("verdict", want.verdict, got.verdict);
                cmp_field("added_in_packet", want.added, got.added);
                cmp_field("entries_held", want.held, got.held);
                cmp_field("final_result", want.fin, got.fin);
                if (want.kind) packets_seen++;
                else verdict_cnt[int'(want.verdict)]++;
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table at the reset capacity, then one
    // random phase per capacity setting. The table carries over between
    // phases, so the small settings also exercise a capacity below the count.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned sent;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int unsigned k = 0; k < DIR_ROWS; k++)
            push_byte(dir_rows[k].data, dir_rows[k].last, dir_rows[k].typed, dir_rows[k].want);
        settle(SETTLE);

        for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
            write_capacity(cap_plan[ph]);
            if (ph == 0) long_hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                fill_packet();
                for (int unsigned k = 0; k < pkt.size(); k++)
                    push_byte(pkt[k], k == pkt.size() - 1, 1'b0, NO_RESULT);
                sent += pkt.size();
            end
            settle((ph == N_PHASES - 1) ? TAIL_WAIT : SETTLE);
        end

        $display("Run covered %0d bytes in %0d packets over %0d capacity settings",
                 bytes_sent, packets_seen, N_PHASES + 1);
        $display("Record verdicts: %0d added, %0d duplicate, %0d full, %0d port zero",
                 verdict_cnt[0], verdict_cnt[1], verdict_cnt[2], verdict_cnt[3]);
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
